// ===== hw/rtl/swat_pkg.sv =====
// ----------------------------------------------------------------------------
// swat_pkg
// Shared field widths, scale constants and the window sample type.
// ----------------------------------------------------------------------------
package swat_pkg;

	// input field widths
	localparam int TEMP_W = 11;
	localparam int HUM_W  = 10;
	localparam int PH_W   = 10;
	localparam int SOIL_W = 10;

	// result field widths
	localparam int PH_AVG_W   = 11;
	localparam int SOIL_PCT_W = 7;

	// pH scaling: raw * 1400 / (1023 * n)
	localparam int PH_SCALE    = 1400;
	localparam int PH_SCALE_W  = 11;
	localparam int PH_FULL_RAW = 1023;

	// soil map span and clamp
	localparam int SOIL_SPAN    = 100;
	localparam int SOIL_NUM_W   = 17;

	// one window entry, held by one cell
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic        [HUM_W-1:0]  humid;
		logic        [PH_W-1:0]   ph;
	} sample_t;

endpackage

// ===== hw/rtl/swat_cell.sv =====
// ----------------------------------------------------------------------------
// swat_cell
// One window cell: holds one sample and takes its neighbor's when enabled.
// ----------------------------------------------------------------------------
module swat_cell (
	input  logic             clk,
	input  logic             en,
	input  swat_pkg::sample_t d,
	output swat_pkg::sample_t q
);

	swat_pkg::sample_t sample_q;

	// payload only, no reset: contents are unknown until written
	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

// ===== hw/rtl/swat_div.sv =====
// ----------------------------------------------------------------------------
// swat_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swat_div #(
	parameter int NW = 17,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [NW-1:0]    quot_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             ge;
	logic [NW:0]      quot_shift;

	// one restoring step
	assign trial      = {rem_q, quot_q[NW-1]};
	assign ge         = trial >= {1'b0, den_q};
	assign diff       = trial - {1'b0, den_q};
	assign quot_shift = {quot_q, ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			quot_q <= quot_shift[NW-1:0];
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/sensor_window_average_thermostat.sv =====
// ----------------------------------------------------------------------------
// sensor_window_average_thermostat
// Windowed sensor averages with lamp hysteresis, pump, valve and soil map.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one sensor word. A word with
//   sensor_ok low is taken and dropped: no state change, no result.
//   A good word is shifted into a ring of WINDOW_LEN cells. The ring then
//   rotates once around while the sums pick up the entries written so far.
//   A prep state scales the sums, then a start register starts four serial
//   dividers in parallel; the pH divider is the longest, and the result
//   register loads once all four are done. The block takes one item at a
//   time: the next word is taken at the earliest in the cycle after the
//   result loads. in_stall is high while an item is in work.
//   Output channel (out_valid / out_stall) is a result register: the next
//   word may be taken while it waits. If it still waits when the next result
//   is ready, the dividers hold their results until it is taken.
//   Reset (arst_n low) clears the fill count, the lamp, both channels and
//   loads the register defaults; window contents are unknown until written.
//   Registers sit on an APB-style port at byte address 4 * index.
// ----------------------------------------------------------------------------
module sensor_window_average_thermostat #(
	parameter int WINDOW_LEN = 10
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// input word
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        sensor_ok,
	input  logic signed [10:0] temperature,
	input  logic [9:0]  humidity,
	input  logic [9:0]  ph_raw,
	input  logic [9:0]  soil_raw,
	input  logic        level_high,

	// result word
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [10:0] temp_average,
	output logic [9:0]  humid_average,
	output logic [10:0] ph_average,
	output logic [6:0]  soil_percent,
	output logic        lamp_on,
	output logic        water_pump_on,
	output logic        valve_drive
);

	localparam int TW  = swat_pkg::TEMP_W;
	localparam int HW  = swat_pkg::HUM_W;
	localparam int PW  = swat_pkg::PH_W;
	localparam int SW  = swat_pkg::SOIL_W;
	localparam int CW  = $clog2(WINDOW_LEN + 1);
	localparam int TSW = TW + CW;
	localparam int HSW = HW + CW;
	localparam int PSW = PW + CW;
	localparam int PNW = PSW + swat_pkg::PH_SCALE_W;
	localparam int PDW = CW + PW;
	localparam int SNW = swat_pkg::SOIL_NUM_W;
	localparam int SOIL_PW = swat_pkg::SOIL_PCT_W;

	// register indexes
	localparam logic [2:0] REG_TEMP_SP  = 3'd0;
	localparam logic [2:0] REG_HUMID_SP = 3'd1;
	localparam logic [2:0] REG_HYST     = 3'd2;
	localparam logic [2:0] REG_SOIL_DRY = 3'd3;
	localparam logic [2:0] REG_SOIL_WET = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_PREP,
		ST_DIV
	} state_t;

	state_t state_q;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic signed [TW-1:0] temp_sp_q;
	logic [HW-1:0]        humid_sp_q;
	logic [7:0]           hyst_q;
	logic [SW-1:0]        soil_dry_q;
	logic [SW-1:0]        soil_wet_q;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_sp_q  <= TW'(400);
			humid_sp_q <= HW'(500);
			hyst_q     <= 8'd20;
			soil_dry_q <= SW'(1023);
			soil_wet_q <= SW'(400);
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_TEMP_SP:  temp_sp_q  <= pwdata[TW-1:0];
				REG_HUMID_SP: humid_sp_q <= pwdata[HW-1:0];
				REG_HYST:     hyst_q     <= pwdata[7:0];
				REG_SOIL_DRY: soil_dry_q <= pwdata[SW-1:0];
				REG_SOIL_WET: soil_wet_q <= pwdata[SW-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[4:2])
			REG_TEMP_SP:  prdata = {{(32-TW){temp_sp_q[TW-1]}}, temp_sp_q};
			REG_HUMID_SP: prdata = {{(32-HW){1'b0}}, humid_sp_q};
			REG_HYST:     prdata = {24'd0, hyst_q};
			REG_SOIL_DRY: prdata = {{(32-SW){1'b0}}, soil_dry_q};
			REG_SOIL_WET: prdata = {{(32-SW){1'b0}}, soil_wet_q};
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// window ring of cells
	// ------------------------------------------------------------------
	logic              accept;
	logic              accept_good;
	logic              ring_en;
	swat_pkg::sample_t new_sample;
	swat_pkg::sample_t cell_d [WINDOW_LEN];
	swat_pkg::sample_t cell_q [WINDOW_LEN];

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign accept_good = accept && sensor_ok;
	assign ring_en     = accept_good || (state_q == ST_SUM);

	assign new_sample.temp  = temperature;
	assign new_sample.humid = humidity;
	assign new_sample.ph    = ph_raw;

	// shift in a new sample when idle, rotate while summing
	assign cell_d[0] = (state_q == ST_IDLE) ? new_sample : cell_q[WINDOW_LEN-1];

	for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
		if (k > 0) begin : g_link
			assign cell_d[k] = cell_q[k-1];
		end
		swat_cell u_cell (
			.clk (clk),
			.en  (ring_en),
			.d   (cell_d[k]),
			.q   (cell_q[k])
		);
	end

	// ------------------------------------------------------------------
	// dividers
	// ------------------------------------------------------------------
	logic           div_start_q;
	logic [TSW-1:0] t_num_q;
	logic           t_neg_q;
	logic [PNW-1:0] p_num_q;
	logic [PDW-1:0] p_den_q;
	logic [SNW-1:0] s_num_q;
	logic [SW-1:0]  s_den_q;
	logic           s_neg_q;
	logic           s_zero_q;
	logic [CW-1:0]  fill_q;
	logic signed [TSW-1:0] tsum_q;
	logic [HSW-1:0] hsum_q;
	logic [PSW-1:0] psum_q;
	logic [SW-1:0]  soil_raw_q;

	logic           t_busy, h_busy, p_busy, s_busy;
	logic [TSW-1:0] t_quot;
	logic [CW-1:0]  t_rem;
	logic [HSW-1:0] h_quot;
	logic [CW-1:0]  h_rem;
	logic [PNW-1:0] p_quot;
	logic [PDW-1:0] p_rem;
	logic [SNW-1:0] s_quot;
	logic [SW-1:0]  s_rem;

	swat_div #(.NW(TSW), .DW(CW)) u_div_temp (
		.clk (clk), .arst_n (arst_n), .start (div_start_q),
		.num (t_num_q), .den (fill_q),
		.busy (t_busy), .quot (t_quot), .rem (t_rem)
	);

	swat_div #(.NW(HSW), .DW(CW)) u_div_humid (
		.clk (clk), .arst_n (arst_n), .start (div_start_q),
		.num (hsum_q), .den (fill_q),
		.busy (h_busy), .quot (h_quot), .rem (h_rem)
	);

	swat_div #(.NW(PNW), .DW(PDW)) u_div_ph (
		.clk (clk), .arst_n (arst_n), .start (div_start_q),
		.num (p_num_q), .den (p_den_q),
		.busy (p_busy), .quot (p_quot), .rem (p_rem)
	);

	swat_div #(.NW(SNW), .DW(SW)) u_div_soil (
		.clk (clk), .arst_n (arst_n), .start (div_start_q),
		.num (s_num_q), .den (s_den_q),
		.busy (s_busy), .quot (s_quot), .rem (s_rem)
	);

	// ------------------------------------------------------------------
	// prep: magnitudes and scaled operands
	// ------------------------------------------------------------------
	logic                 tsum_neg;
	logic [TSW-1:0]       tsum_mag;
	logic signed [SW:0]   soil_dn;
	logic signed [SW:0]   soil_dd;
	logic [SW-1:0]        soil_dn_mag;
	logic [SW-1:0]        soil_dd_mag;
	logic [SW:0]          soil_dn_neg;
	logic [SW:0]          soil_dd_neg;

	assign tsum_neg    = tsum_q[TSW-1];
	assign tsum_mag    = tsum_neg ? (~tsum_q + 1'b1) : tsum_q;
	assign soil_dn     = {1'b0, soil_raw_q} - {1'b0, soil_dry_q};
	assign soil_dd     = {1'b0, soil_wet_q} - {1'b0, soil_dry_q};
	assign soil_dn_neg = -soil_dn;
	assign soil_dd_neg = -soil_dd;
	assign soil_dn_mag = soil_dn[SW] ? soil_dn_neg[SW-1:0] : soil_dn[SW-1:0];
	assign soil_dd_mag = soil_dd[SW] ? soil_dd_neg[SW-1:0] : soil_dd[SW-1:0];

	// ------------------------------------------------------------------
	// results
	// ------------------------------------------------------------------
	logic                 div_done;
	logic                 load_res;
	logic                 sum_tap;
	logic [CW:0]          tap_pos;
	logic signed [TW-1:0] tavg;
	logic [HW-1:0]        havg;
	logic [SOIL_PW-1:0]   soil_pct;
	logic signed [TW+1:0] lamp_lo;
	logic signed [TW+1:0] lamp_hi;
	logic signed [TW+1:0] tavg_x;
	logic                 lamp_next;
	logic [TW-1:0]        t_q_low;
	logic [CW-1:0]        step_q;
	logic                 level_q;
	logic                 lamp_q;
	logic                 out_valid_q;
	logic signed [TW-1:0] temp_avg_q;
	logic [HW-1:0]        humid_avg_q;
	logic [swat_pkg::PH_AVG_W-1:0] ph_avg_q;
	logic [SOIL_PW-1:0]   soil_pct_q;
	logic                 pump_q;
	logic                 valve_q;

	assign div_done = !div_start_q && !t_busy && !h_busy && !p_busy && !s_busy;

	// result register loads once the dividers are done and the slot is free
	assign load_res = (state_q == ST_DIV) && div_done && (!out_valid_q || !out_stall);

	// the last cell leaves entry WINDOW_LEN-1-step; count it once it was written
	assign tap_pos = {1'b0, step_q} + {1'b0, fill_q};
	assign sum_tap = tap_pos >= (CW+1)'(WINDOW_LEN);

	// floor for a negative sum: -q when exact, else -q-1
	assign t_q_low = t_quot[TW-1:0];
	assign tavg    = t_neg_q ? (~t_q_low + TW'(t_rem == '0)) : t_q_low;
	assign havg    = h_quot[HW-1:0];

	always_comb begin
		if (s_zero_q || (s_neg_q && (s_quot != '0))) begin
			soil_pct = '0;
		end else if (s_quot > SNW'(swat_pkg::SOIL_SPAN)) begin
			soil_pct = SOIL_PW'(swat_pkg::SOIL_SPAN);
		end else begin
			soil_pct = s_quot[SOIL_PW-1:0];
		end
	end

	// lamp hysteresis on the floored mean
	assign lamp_lo = (TW+2)'(temp_sp_q) - (TW+2)'($signed({1'b0, hyst_q}));
	assign lamp_hi = (TW+2)'(temp_sp_q) + (TW+2)'($signed({1'b0, hyst_q}));
	assign tavg_x  = (TW+2)'(tavg);

	always_comb begin
		if (tavg_x < lamp_lo) begin
			lamp_next = 1'b1;
		end else if (tavg_x > lamp_hi) begin
			lamp_next = 1'b0;
		end else begin
			lamp_next = lamp_q;
		end
	end

	// ------------------------------------------------------------------
	// sequencer: control, sums and result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			step_q      <= '0;
			div_start_q <= 1'b0;
			lamp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= (state_q == ST_PREP);
			out_valid_q <= load_res || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (accept_good) begin
						if (fill_q != CW'(WINDOW_LEN)) begin
							fill_q <= fill_q + 1'b1;
						end
						step_q     <= '0;
						tsum_q     <= '0;
						hsum_q     <= '0;
						psum_q     <= '0;
						soil_raw_q <= soil_raw;
						level_q    <= level_high;
						state_q    <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (sum_tap) begin
						tsum_q <= tsum_q + TSW'(cell_q[WINDOW_LEN-1].temp);
						hsum_q <= hsum_q + HSW'(cell_q[WINDOW_LEN-1].humid);
						psum_q <= psum_q + PSW'(cell_q[WINDOW_LEN-1].ph);
					end
					step_q <= step_q + 1'b1;
					if (step_q == CW'(WINDOW_LEN - 1)) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					t_num_q     <= tsum_mag;
					t_neg_q     <= tsum_neg;
					p_num_q     <= PNW'(psum_q) * PNW'(swat_pkg::PH_SCALE);
					p_den_q     <= PDW'(fill_q) * PDW'(swat_pkg::PH_FULL_RAW);
					s_num_q     <= SNW'(soil_dn_mag) * SNW'(swat_pkg::SOIL_SPAN);
					s_den_q     <= soil_dd_mag;
					s_neg_q     <= soil_dn[SW] ^ soil_dd[SW];
					s_zero_q    <= (soil_wet_q == soil_dry_q);
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (load_res) begin
						temp_avg_q  <= tavg;
						humid_avg_q <= havg;
						ph_avg_q    <= p_quot[swat_pkg::PH_AVG_W-1:0];
						soil_pct_q  <= soil_pct;
						lamp_q      <= lamp_next;
						pump_q      <= (havg < humid_sp_q);
						valve_q     <= !level_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign temp_average  = temp_avg_q;
	assign humid_average = humid_avg_q;
	assign ph_average    = ph_avg_q;
	assign soil_percent  = soil_pct_q;
	assign lamp_on       = lamp_q;
	assign water_pump_on = pump_q;
	assign valve_drive   = valve_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// fill count saturates at the window length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WINDOW_LEN))
		else $error("fill count beyond window length");

	// a good word always starts a ring rotation
	a_good_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sensor_ok) |=> (state_q == ST_SUM))
		else $error("good word did not start summing");

	// a new result only comes out of the divide phase
	a_result_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q && out_stall) && $past(arst_n))
			|-> $past(state_q == ST_DIV && div_done))
		else $error("result loaded outside divide phase");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the windowed sensor average thermostat.
// Sends sensor words with random gaps and result stalls, and predicts each
// result in the bench itself: window means, lamp hysteresis, pump, valve and
// soil percent. Results are checked field by field, in order. A short table
// of hand-picked words and register writes runs first. Random phases follow,
// one per register setting.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WINDOW_LEN      = 10;
	localparam int SETTLE_CYCLES   = 80;
	localparam int QUIET_LIMIT     = 2000;
	localparam int WORDS_PER_PHASE = 135;
	localparam int REPORT_MAX      = 10;
	localparam int PHASE_COUNT     = 7;

	typedef enum logic [2:0] {
		REG_TEMP_SETPOINT  = 3'd0,
		REG_HUMID_SETPOINT = 3'd1,
		REG_HYST_BAND      = 3'd2,
		REG_SOIL_DRY       = 3'd3,
		REG_SOIL_WET       = 3'd4,
		REG_SPARE          = 3'd5
	} reg_index_e;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

	typedef struct packed {
		logic              ok;
		logic signed [10:0] temp;
		logic [9:0]        humid;
		logic [9:0]        ph;
		logic [9:0]        soil;
		logic              level;
	} word_t;

	typedef struct packed {
		logic signed [10:0] temp_avg;
		logic [9:0]        humid_avg;
		logic [10:0]       ph_avg;
		logic [6:0]        soil_pct;
		logic              lamp;
		logic              pump;
		logic              valve;
	} reading_t;

	typedef struct packed {
		row_kind_e   kind;
		word_t       word;
		reg_index_e  idx;
		logic [31:0] value;
		logic        typed;   // expected result written in below
		reading_t    want;
	} spot_row_t;

	localparam word_t    NO_WORD    = '0;
	localparam reading_t NO_READING = '0;

	// hand-picked words and writes; 11'h400 is -1024
	localparam spot_row_t SPOT_CHECKS [25] = '{
		'{ROW_WORD, '{1'b1, 11'sd400, 10'd600, 10'd1023, 10'd1023, 1'b1}, REG_SPARE, 32'd0,
			1'b1, '{11'sd400, 10'd600, 11'd1400, 7'd0, 1'b0, 1'b0, 1'b0}},
		'{ROW_WORD, '{1'b0, 11'h400, 10'd1023, 10'd1023, 10'd1023, 1'b0}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, -11'sd400, 10'd0, 10'd0, 10'd400, 1'b0}, REG_SPARE, 32'd0,
			1'b1, '{11'sd0, 10'd300, 11'd700, 7'd100, 1'b1, 1'b1, 1'b1}},
		'{ROW_WORD, '{1'b1, 11'h400, 10'd1023, 10'd1023, 10'd0, 1'b1}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd800, 10'd1000, 10'd512, 10'd700, 1'b1}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd800, 10'd1000, 10'd0, 10'd650, 1'b0}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd800, 10'd1000, 10'd511, 10'd401, 1'b1}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd800, 10'd1000, 10'd1, 10'd399, 1'b0}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd800, 10'd1000, 10'd1022, 10'd1022, 1'b1}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd379, 10'd999, 10'd3, 10'd2, 1'b0}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd421, 10'd498, 10'd700, 10'd800, 1'b1}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b0, 11'sd0, 10'd0, 10'd0, 10'd0, 1'b0}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_REG, NO_WORD, REG_SOIL_WET, 32'd512, 1'b0, NO_READING},
		'{ROW_REG, NO_WORD, REG_SOIL_DRY, 32'd512, 1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd420, 10'd500, 10'd256, 10'd1023, 1'b0}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_REG, NO_WORD, REG_SPARE, 32'h3FF, 1'b0, NO_READING},
		'{ROW_REG, NO_WORD, REG_HYST_BAND, 32'd0, 1'b0, NO_READING},
		'{ROW_REG, NO_WORD, REG_TEMP_SETPOINT, 32'hFFFF_FC00, 1'b0, NO_READING},
		'{ROW_REG, NO_WORD, REG_HUMID_SETPOINT, 32'd1023, 1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'h400, 10'd1022, 10'd100, 10'd0, 1'b1}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_REG, NO_WORD, REG_SOIL_DRY, 32'd0, 1'b0, NO_READING},
		'{ROW_REG, NO_WORD, REG_SOIL_WET, 32'd1023, 1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd1023, 10'd0, 10'd1023, 10'd511, 1'b0}, REG_SPARE, 32'd0,
			1'b0, NO_READING},
		'{ROW_WORD, '{1'b1, 11'sd380, 10'd1, 10'd0, 10'd1023, 1'b1}, REG_SPARE, 32'd0,
			1'b0, NO_READING}
	};

	// register settings per random phase:
	// temp setpoint, humid setpoint, band, soil dry, soil wet
	localparam int PHASE_CFG [PHASE_COUNT][5] = '{
		'{  400,  500,  20, 1023,  400},
		'{ -400,    0,   0,    0, 1023},
		'{  800, 1000, 200, 1023,    0},
		'{-1024, 1023, 255,  512,  512},
		'{ 1023,    0, 255,    0,    0},
		'{  250,  600,   5,  900,  300},
		'{    0,  300,   1,  100,  800}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               sensor_ok = 1'b0;
	logic signed [10:0] temperature = '0;
	logic [9:0]         humidity = '0;
	logic [9:0]         ph_raw = '0;
	logic [9:0]         soil_raw = '0;
	logic               level_high = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [10:0] temp_average;
	logic [9:0]         humid_average;
	logic [10:0]        ph_average;
	logic [6:0]         soil_percent;
	logic               lamp_on;
	logic               water_pump_on;
	logic               valve_drive;

	// predictor state and register copies
	int  win_temp [WINDOW_LEN];
	int  win_humid [WINDOW_LEN];
	int  win_ph [WINDOW_LEN];
	int  fill_slot = 0;
	bit  wrapped = 1'b0;
	bit  heater = 1'b0;
	int  cfg_temp_sp = 400;
	int  cfg_humid_sp = 500;
	int  cfg_band = 20;
	int  cfg_soil_dry = 1023;
	int  cfg_soil_wet = 400;

	reading_t pending_readings [$];
	int       mismatches = 0;
	int       quiet_cycles = 0;
	bit       calm = 1'b0;   // no idling on either side

	sensor_window_average_thermostat #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_top (.*);

	always #5 clk = ~clk;

	// window means, lamp hysteresis and soil map for one word
	function automatic bit predict_reading(input word_t w, output reading_t r);
		int sum_t, sum_h, sum_p, cnt, avg_t, avg_h, soil;
		r = '0;
		if (!w.ok)
			return 1'b0;
		win_temp[fill_slot]  = int'($signed(w.temp));
		win_humid[fill_slot] = int'(w.humid);
		win_ph[fill_slot]    = int'(w.ph);
		fill_slot++;
		if (fill_slot == WINDOW_LEN) begin
			fill_slot = 0;
			wrapped   = 1'b1;
		end
		cnt = wrapped ? WINDOW_LEN : fill_slot;
		sum_t = 0;
		sum_h = 0;
		sum_p = 0;
		for (int i = 0; i < cnt; i++) begin
			sum_t += win_temp[i];
			sum_h += win_humid[i];
			sum_p += win_ph[i];
		end
		// floored mean, also for negative sums
		avg_t = sum_t / cnt;
		if ((sum_t % cnt) != 0 && sum_t < 0)
			avg_t = avg_t - 1;
		avg_h = sum_h / cnt;
		if (avg_t < cfg_temp_sp - cfg_band)
			heater = 1'b1;
		else if (avg_t > cfg_temp_sp + cfg_band)
			heater = 1'b0;
		// soil map, truncated toward zero, then clamped
		if (cfg_soil_wet == cfg_soil_dry) begin
			soil = 0;
		end else begin
			soil = (int'(w.soil) - cfg_soil_dry) * 100 / (cfg_soil_wet - cfg_soil_dry);
			if (soil < 0)
				soil = 0;
			if (soil > 100)
				soil = 100;
		end
		r.temp_avg  = 11'(avg_t);
		r.humid_avg = 10'(avg_h);
		r.ph_avg    = 11'((sum_p * 1400) / (1023 * cnt));
		r.soil_pct  = 7'(soil);
		r.lamp      = heater;
		r.pump      = avg_h < cfg_humid_sp;
		r.valve     = !w.level;
		return 1'b1;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// offer one word, with a random gap first, and record its expectation
	task automatic offer_word(input word_t w, input bit typed, input reading_t want);
		reading_t got;
		int gap;
		if (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 45);
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		sensor_ok   <= w.ok;
		temperature <= w.temp;
		humidity    <= w.humid;
		ph_raw      <= w.ph;
		soil_raw    <= w.soil;
		level_high  <= w.level;
		do @(posedge clk); while (in_stall);
		if (predict_reading(w, got))
			pending_readings.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	// hold off until every result is in and the block has gone quiet
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input reg_index_e idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TEMP_SETPOINT:  cfg_temp_sp  = int'($signed(value[10:0]));
			REG_HUMID_SETPOINT: cfg_humid_sp = int'(value[9:0]);
			REG_HYST_BAND:      cfg_band     = int'(value[7:0]);
			REG_SOIL_DRY:       cfg_soil_dry = int'(value[9:0]);
			REG_SOIL_WET:       cfg_soil_wet = int'(value[9:0]);
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// result side stall
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 38);
	end

	// compare each taken result word with the oldest expectation
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result word with no expectation: temp %0d humid %0d ph %0d",
						$time, temp_average, humid_average, ph_average);
			end else begin
				want = pending_readings.pop_front();
				check_field("temp_average", int'($signed(want.temp_avg)),
					int'(temp_average));
				check_field("humid_average", int'(want.humid_avg), int'(humid_average));
				check_field("ph_average", int'(want.ph_avg), int'(ph_average));
				check_field("soil_percent", int'(want.soil_pct), int'(soil_percent));
				check_field("lamp_on", int'(want.lamp), int'(lamp_on));
				check_field("water_pump_on", int'(want.pump), int'(water_pump_on));
				check_field("valve_drive", int'(want.valve), int'(valve_drive));
			end
		end
	end

	// watchdog: too long with nothing taken on any port
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus
	initial begin
		word_t w;
		int    good, t, h, drift, step, span;
		bit    drift_up;

		drift    = 0;
		drift_up = 1'b1;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// hand-picked words and writes
		foreach (SPOT_CHECKS[i]) begin
			if (SPOT_CHECKS[i].kind == ROW_REG) begin
				settle_idle();
				write_register(SPOT_CHECKS[i].idx, SPOT_CHECKS[i].value);
			end else begin
				offer_word(SPOT_CHECKS[i].word, SPOT_CHECKS[i].typed, SPOT_CHECKS[i].want);
			end
		end

		// random phases, one register setting each
		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle_idle();
			for (int r = 0; r < 5; r++)
				write_register(reg_index_e'(r), PHASE_CFG[p][r]);
			calm = (p == 2);
			drift = 0;
			good = 0;
			while (good < WORDS_PER_PHASE) begin
				w.ok = $urandom_range(99) >= 10;
				// temperature drifts across the hysteresis band
				span = cfg_band + 60;
				step = $urandom_range(0, 12);
				drift = drift_up ? drift + step : drift - step;
				if (drift > span)
					drift_up = 1'b0;
				else if (drift < -span)
					drift_up = 1'b1;
				if ($urandom_range(99) < 65)
					t = cfg_temp_sp + drift + int'($urandom_range(0, 40)) - 20;
				else
					t = int'($urandom_range(0, 2047)) - 1024;
				if (t > 1023)
					t = 1023;
				if (t < -1024)
					t = -1024;
				w.temp = 11'(t);
				if ($urandom_range(99) < 70)
					h = cfg_humid_sp + int'($urandom_range(0, 200)) - 100;
				else
					h = int'($urandom_range(0, 1023));
				if (h > 1023)
					h = 1023;
				if (h < 0)
					h = 0;
				w.humid = 10'(h);
				w.ph    = 10'($urandom_range(0, 1023));
				if ($urandom_range(99) < 50)
					w.soil = 10'($urandom_range(cfg_soil_dry, cfg_soil_wet));
				else
					w.soil = 10'($urandom_range(0, 1023));
				w.level = $urandom_range(0, 1);
				offer_word(w, 1'b0, NO_READING);
				if (w.ok)
					good++;
			end
			calm = 1'b0;
		end

		settle_idle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
